>>> hw/rtl/tlpm_pkg.sv
// shared constants and codes for the trie longest prefix match block
// no dependencies; used by the interfaces, the node store and the top level
package tlpm_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int ADDR_W = 32;
  localparam int LEN_W = 6;
  localparam int PORT_W = 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // register index, taken from paddr above the byte offset
  localparam logic [APB_AW-3:0] REG_DEFAULT_PORT = '0;

endpackage

>>> hw/rtl/tlpm_if.sv
// valid/ready channels for the trie longest prefix match block
// depends on tlpm_pkg for the field widths
interface tlpm_req_if;
  import tlpm_pkg::*;
  logic valid;
  logic ready;
  logic action;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0] prefix_length;
  logic [PORT_W-1:0] port_in;

  modport source(output valid, output action, output address, output prefix_length,
                 output port_in, input ready);
  modport sink(input valid, input action, input address, input prefix_length,
               input port_in, output ready);
endinterface

interface tlpm_rsp_if;
  import tlpm_pkg::*;
  logic valid;
  logic ready;
  logic [PORT_W-1:0] out_port;
  logic matched;
  logic status;

  modport source(output valid, output out_port, output matched, output status,
                 input ready);
  modport sink(input valid, input out_port, input matched, input status,
               output ready);
endinterface

>>> hw/rtl/trie_longest_prefix_match.sv
// top level of the binary trie longest prefix match (ipv4 forwarding lookup)
// depends on tlpm_pkg, tlpm_if and tlpm_node_store
//
//   channel  kind         payload
//   req      valid/ready  action, address, prefix_length, port_in
//   rsp      valid/ready  out_port, matched, status
//   apb      apb          default_port at byte address 0, read and write
//
// a word is taken while idle, walks down the trie (at most 32 levels below the root)
// and then waits in S_DONE until the output register on rsp is free.
// the walk is bound by the single read port of the node store; a new child is
// taken from the free counter in the same cycle without a read.
// rst is synchronous; it empties the root and sets the free counter to 1.
// req.ready is high only while idle; a result waiting on rsp stalls the next one
// in S_DONE, after that word has already been taken and walked.
module trie_longest_prefix_match #(
  parameter int NODE_COUNT = tlpm_pkg::NODE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  tlpm_req_if.sink                       req,
  tlpm_rsp_if.source                     rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlpm_pkg::APB_AW-1:0]    paddr,
  input  logic [tlpm_pkg::APB_DW-1:0]    pwdata,
  output logic [tlpm_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import tlpm_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int CW = IW + 1;
  localparam int EW = 2 * IW + PORT_W + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef struct packed {
    logic              marked;
    logic [PORT_W-1:0] port;
    logic [IW-1:0]     left;
    logic [IW-1:0]     right;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [PORT_W-1:0] default_port;
  logic [CW-1:0]     next_free;

  logic              action_q;
  logic [ADDR_W-1:0] addr_sh;
  logic [LEN_W-1:0]  len_q;
  logic [PORT_W-1:0] port_q;
  logic [LEN_W-1:0]  level;
  logic [IW-1:0]     cur_node;
  node_t             cur_entry;
  logic              use_rd;
  logic              hit;
  logic [PORT_W-1:0] best_port;
  logic [PORT_W-1:0] res_port;
  logic              res_matched;
  logic              res_status;
  logic              rsp_valid;
  logic [PORT_W-1:0] rsp_port;
  logic              rsp_matched;
  logic              rsp_status;

  logic              item_acc;
  logic              cfg_wr;
  logic [LEN_W-1:0]  len_sat;
  node_t             entry;
  node_t             upd;
  node_t             marked_entry;
  logic              go_right;
  logic [IW-1:0]     child;
  logic              store_full;
  logic              at_end;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [EW-1:0]     rd_data;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;

  tlpm_node_store #(
    .NODE_COUNT(NODE_COUNT),
    .EW        (EW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign req.ready = (state == S_IDLE) && !rst;
  assign item_acc = req.valid && req.ready;
  assign len_sat = (req.prefix_length > MAX_LEN) ? MAX_LEN : req.prefix_length;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[APB_AW-1:2] == REG_DEFAULT_PORT) ?
                  {{(APB_DW - PORT_W){1'b0}}, default_port} : '0;

  assign rsp.valid = rsp_valid;
  assign rsp.out_port = rsp_port;
  assign rsp.matched = rsp_matched;
  assign rsp.status = rsp_status;

  // current node comes from the store after a descent, or from the register
  // for a node just taken from the free counter
  always_comb begin
    entry = use_rd ? node_t'(rd_data) : cur_entry;
    go_right = addr_sh[ADDR_W-1];
    child = go_right ? entry.right : entry.left;
    store_full = (next_free >= CW'(NODE_COUNT));
    at_end = (action_q == ACT_LOOKUP) ? (level == MAX_LEN) : (level == len_q);

    upd = entry;
    if (go_right) begin
      upd.right = next_free[IW-1:0];
    end else begin
      upd.left = next_free[IW-1:0];
    end
    marked_entry = entry;
    marked_entry.marked = 1'b1;
    marked_entry.port = port_q;

    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = cur_node;
    wr_data = EW'(entry);

    unique case (state)
      S_IDLE: begin
        rd_en = item_acc;
      end
      S_WALK: begin
        if (action_q == ACT_LOOKUP) begin
          if (!at_end && child != IW'(0)) begin
            rd_en = 1'b1;
            rd_addr = child;
          end
        end else if (at_end) begin
          wr_en = 1'b1;
          wr_data = EW'(marked_entry);
        end else if (child != IW'(0)) begin
          rd_en = 1'b1;
          rd_addr = child;
        end else if (store_full) begin
          // write back so a node taken earlier in this walk exists as empty
          wr_en = 1'b1;
        end else begin
          wr_en = 1'b1;
          wr_data = EW'(upd);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_free <= CW'(1);
      default_port <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr && paddr[APB_AW-1:2] == REG_DEFAULT_PORT) begin
        default_port <= pwdata[PORT_W-1:0];
      end
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (req.action == ACT_INSERT && len_sat == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (action_q == ACT_LOOKUP) begin
            if (at_end || child == IW'(0)) begin
              state <= S_DONE;
            end
          end else if (at_end) begin
            state <= S_DONE;
          end else if (child == IW'(0)) begin
            if (store_full) begin
              state <= S_DONE;
            end else begin
              next_free <= next_free + CW'(1);
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (item_acc) begin
          action_q <= req.action;
          addr_sh <= req.address;
          len_q <= len_sat;
          port_q <= req.port_in;
          level <= '0;
          cur_node <= '0;
          use_rd <= 1'b1;
          hit <= 1'b0;
          best_port <= default_port;
          res_port <= '0;
          res_matched <= 1'b0;
          res_status <= STATUS_OK;
        end
      end
      S_WALK: begin
        if (action_q == ACT_LOOKUP) begin
          if (entry.marked) begin
            hit <= 1'b1;
            best_port <= entry.port;
          end
          if (at_end || child == IW'(0)) begin
            res_port <= entry.marked ? entry.port : best_port;
            res_matched <= hit || entry.marked;
            res_status <= STATUS_OK;
          end else begin
            cur_node <= child;
            use_rd <= 1'b1;
            level <= level + LEN_W'(1);
            addr_sh <= addr_sh << 1;
          end
        end else if (at_end) begin
          res_port <= port_q;
        end else if (child != IW'(0)) begin
          cur_node <= child;
          use_rd <= 1'b1;
          level <= level + LEN_W'(1);
          addr_sh <= addr_sh << 1;
        end else if (store_full) begin
          res_status <= STATUS_FULL;
        end else begin
          cur_node <= next_free[IW-1:0];
          cur_entry <= '0;
          use_rd <= 1'b0;
          level <= level + LEN_W'(1);
          addr_sh <= addr_sh << 1;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_port <= res_port;
          rsp_matched <= res_matched;
          rsp_status <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/tlpm_node_store.sv
// trie node memory: one write port, one registered read port
// the root lives in a register so that reset can clear it; uses tlpm_pkg
module tlpm_node_store #(
  parameter int NODE_COUNT = tlpm_pkg::NODE_COUNT_DEF,
  parameter int EW = 2 * $clog2(NODE_COUNT) + tlpm_pkg::PORT_W + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  output logic [EW-1:0]                 rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  input  logic [EW-1:0]                 wr_data
);
  localparam int IW = $clog2(NODE_COUNT);

  logic [EW-1:0] mem [NODE_COUNT];
  logic [EW-1:0] rd_q;
  logic [EW-1:0] root;
  logic          root_sel;

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr != IW'(0)) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
      root_sel <= 1'b0;
    end else begin
      if (wr_en && wr_addr == IW'(0)) begin
        root <= wr_data;
      end
      if (rd_en) begin
        root_sel <= (rd_addr == IW'(0));
      end
    end
  end

  assign rd_data = root_sel ? root : rd_q;

endmodule

>>> hw/rtl/tlpm_checker.sv
// port-level checks for trie_longest_prefix_match, attached by bind
// depends on tlpm_pkg for the port width
module tlpm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [tlpm_pkg::PORT_W-1:0] rsp_out_port,
  input logic                        rsp_matched,
  input logic                        rsp_status
);
  import tlpm_pkg::*;

  // a waiting result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_port) &&
    $stable(rsp_matched) && $stable(rsp_status))
    else $error("rsp word changed while stalled");

  // one word in flight: ready drops right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req taken again while busy");

  // an abandoned insert reports no port and no match
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STATUS_FULL |-> !rsp_matched && rsp_out_port == '0)
    else $error("store full result carries a port or match");

  // a result never shows up in the cycle after a word is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_valid && req_ready))
    else $error("result too early");

endmodule

bind trie_longest_prefix_match tlpm_checker u_tlpm_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_out_port(rsp.out_port),
  .rsp_matched (rsp.matched),
  .rsp_status  (rsp.status)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for trie_longest_prefix_match: route inserts and lookups
// are checked against a trie predictor; depends on tlpm_pkg, tlpm_if and the rtl
module tb_top;
  import tlpm_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int TOTAL_WORDS = 1350;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [APB_AW-3:0] REG_SPARE = 1'b1;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              hit;
    logic              status;
  } route_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  tlpm_req_if req_ch();
  tlpm_rsp_if rsp_ch();

  trie_longest_prefix_match dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted trie
  logic [12:0] kid_left [NODES];
  logic [12:0] kid_right [NODES];
  logic node_mark [NODES];
  logic [PORT_W-1:0] node_port [NODES];
  logic [12:0] free_node;
  logic [PORT_W-1:0] default_port_q;

  route_result_t pending_routes[$];
  route_result_t want;
  logic [ADDR_W-1:0] known_nets[$];

  int fail_count = 0;
  int n_sent = 0;
  int n_inserts = 0;
  int n_lookups = 0;
  int n_hits = 0;
  int n_full = 0;
  int n_settings = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int rsp_hold_request = 0;
  bit no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic route_result_t trie_insert(input logic [ADDR_W-1:0] net,
                                                input logic [LEN_W-1:0] len_in,
                                                input logic [PORT_W-1:0] port);
    route_result_t res;
    int depth;
    logic [12:0] node;
    logic [12:0] kid;
    logic go_right;
    res.port = '0;
    res.hit = 1'b0;
    res.status = STATUS_OK;
    depth = (len_in > 32) ? 32 : int'(len_in);
    if (depth == 0) return res;
    node = '0;
    for (int i = 0; i < depth; i++) begin
      go_right = net[31-i];
      kid = go_right ? kid_right[node] : kid_left[node];
      if (kid == 0) begin
        if (free_node >= NODES) begin
          res.status = STATUS_FULL;
          return res;
        end
        kid = free_node;
        free_node = free_node + 1;
        kid_left[kid] = '0;
        kid_right[kid] = '0;
        node_mark[kid] = 1'b0;
        node_port[kid] = '0;
        if (go_right) kid_right[node] = kid;
        else kid_left[node] = kid;
      end
      node = kid;
    end
    node_mark[node] = 1'b1;
    node_port[node] = port;
    res.port = port;
    return res;
  endfunction

  function automatic route_result_t trie_lookup(input logic [ADDR_W-1:0] addr);
    route_result_t res;
    logic [12:0] node;
    logic [12:0] kid;
    res.port = default_port_q;
    res.hit = 1'b0;
    res.status = STATUS_OK;
    node = '0;
    for (int i = 0; i < 32; i++) begin
      kid = addr[31-i] ? kid_right[node] : kid_left[node];
      if (kid == 0) break;
      node = kid;
      if (node_mark[node]) begin
        res.hit = 1'b1;
        res.port = node_port[node];
      end
    end
    return res;
  endfunction

  // address sharing a random number of leading bits with a known network
  function automatic logic [ADDR_W-1:0] near_known();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] keep;
    int shared;
    base = known_nets[$urandom_range(0, known_nets.size() - 1)];
    shared = ($urandom_range(0, 99) < 70) ? $urandom_range(16, 32) : $urandom_range(0, 15);
    keep = (shared == 0) ? '0 : ~(32'hFFFF_FFFF >> shared);
    return (base & keep) | ($urandom & ~keep);
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return LEN_W'($urandom_range(33, 63));
    if (r < 20) return LEN_W'($urandom_range(1, 7));
    return LEN_W'($urandom_range(8, 32));
  endfunction

  task automatic send_word(input logic act, input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len, input logic [PORT_W-1:0] port);
    int gap;
    route_result_t res;
    gap = no_idle ? 0 : gap_len();
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      req_ch.address <= $urandom;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.address <= addr;
    req_ch.prefix_length <= len;
    req_ch.port_in <= port;
    do @(posedge clk); while (!req_ch.ready);
    if (act == ACT_INSERT) begin
      res = trie_insert(addr, len, port);
      n_inserts++;
      if (res.status == STATUS_FULL) n_full++;
    end else begin
      res = trie_lookup(addr);
      n_lookups++;
      if (res.hit) n_hits++;
    end
    pending_routes.push_back(res);
    n_sent++;
  endtask

  // drop valid and hold until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-3:0] index, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_DEFAULT_PORT) begin
      default_port_q = data[PORT_W-1:0];
      n_settings++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {REG_DEFAULT_PORT, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(default_port_q)) begin
      $display("%0t: default_port read expected %0d, got %0d", $time, default_port_q, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_default_port(input logic [APB_DW-1:0] data);
    wait_drained();
    apb_write(REG_DEFAULT_PORT, data);
  endtask

  task automatic send_mixed(input int insert_pct, input bit reinsert);
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0] len;
    if ($urandom_range(0, 99) < insert_pct) begin
      addr = ($urandom_range(0, 9) == 0) ? $urandom : near_known();
      len = rand_len();
      if (reinsert && $urandom_range(0, 1)) begin
        addr = known_nets[$urandom_range(0, known_nets.size() - 1)];
        len = LEN_W'($urandom_range(1, 32));
      end
      send_word(ACT_INSERT, addr, len, PORT_W'($urandom));
      if (known_nets.size() < 1024) known_nets.push_back(addr);
    end else begin
      addr = ($urandom_range(0, 9) == 0) ? $urandom : near_known();
      send_word(ACT_LOOKUP, addr, LEN_W'($urandom_range(0, 63)), PORT_W'($urandom));
    end
  endtask

  task automatic test_register_access();
    // lookup on an empty trie falls back to the reset default
    send_word(ACT_LOOKUP, $urandom, '0, '0);
    wait_drained();
    apb_read_check();
    apb_write(REG_DEFAULT_PORT, 32'h5A3C_00A5);
    apb_read_check();
    // write to an unmapped index is dropped
    apb_write(REG_SPARE, 32'h0000_003C);
    apb_read_check();
  endtask

  task automatic test_directed_routes();
    send_word(ACT_INSERT, 32'h0A00_0000, 6'd8, 8'd7);
    send_word(ACT_LOOKUP, 32'h0A01_0203, '0, '0);
    send_word(ACT_INSERT, 32'h0A01_0000, 6'd16, 8'd200);
    send_word(ACT_LOOKUP, 32'h0A01_0203, '0, '0);
    send_word(ACT_LOOKUP, 32'h0A02_0000, '0, '0);
    // shorter prefix ending on an existing inner node
    send_word(ACT_INSERT, 32'h0A00_0000, 6'd4, 8'd33);
    send_word(ACT_LOOKUP, 32'h0B00_0000, '0, '0);
    send_word(ACT_LOOKUP, 32'h0A02_0000, '0, '0);
    // same prefix again overwrites the port
    send_word(ACT_INSERT, 32'h0A00_0000, 6'd8, 8'd99);
    send_word(ACT_LOOKUP, 32'h0A02_0000, '0, '0);
    // zero length is ignored
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 6'd0, 8'hFF);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 6'h3F, 8'hFF);
    // over-long length saturates, lookup walks all 32 levels
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 8'hFF);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFE, '0, '0);
    send_word(ACT_INSERT, 32'h0000_0001, 6'd32, 8'd1);
    send_word(ACT_LOOKUP, 32'h0000_0001, '0, '0);
    send_word(ACT_LOOKUP, 32'h0000_0000, '0, '0);
    send_word(ACT_INSERT, 32'h8000_0000, 6'd1, 8'd128);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFE, '0, '0);
    send_word(ACT_INSERT, 32'h1234_5678, 6'd33, 8'h5A);
    send_word(ACT_LOOKUP, 32'h1234_5678, '0, '0);
    // a stored port of 0 still counts as a match
    send_word(ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'd0);
    send_word(ACT_LOOKUP, 32'hC0A8_1234, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < 16; i++) known_nets.push_back($urandom);
    set_default_port(32'hFFFF_FFFF);
    // back-to-back stretch on both sides
    no_idle = 1'b1;
    repeat (120) send_mixed(50, 1'b0);
    no_idle = 1'b0;
    set_default_port(32'h0000_0000);
    repeat (count - 120) send_mixed(50, 1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_default_port($urandom);
    rsp_hold_request = 400;
    no_idle = 1'b1;
    repeat (16) send_mixed(40, 1'b0);
    no_idle = 1'b0;
    wait_drained();
    repeat (24) send_mixed(40, 1'b0);
    wait_drained();
  endtask

  task automatic test_store_exhaustion();
    int target;
    int tries;
    target = n_full + 8;
    tries = 0;
    while (n_full < target && tries < 600) begin
      if ($urandom_range(0, 3) != 0) begin
        send_word(ACT_INSERT, $urandom,
                  ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(33, 63)) : 6'd32,
                  PORT_W'($urandom));
      end else begin
        send_word(ACT_LOOKUP, near_known(), LEN_W'($urandom), PORT_W'($urandom));
      end
      tries++;
    end
    wait_drained();
  endtask

  task automatic test_full_store_traffic();
    set_default_port(32'h0000_0055);
    while (n_sent < TOTAL_WORDS - 100) send_mixed(30, 1'b1);
    set_default_port(32'hABCD_EF80);
    repeat (100) send_mixed(30, 1'b1);
    wait_drained();
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_routes.size() == 0) begin
        $display("%0t: result with nothing expected: port %0d matched %0d status %0d",
                 $time, rsp_ch.out_port, rsp_ch.matched, rsp_ch.status);
        fail_count++;
      end else begin
        want = pending_routes.pop_front();
        if (rsp_ch.out_port !== want.port) begin
          $display("%0t: out_port expected %0d, got %0d", $time, want.port, rsp_ch.out_port);
          fail_count++;
        end
        if (rsp_ch.matched !== want.hit) begin
          $display("%0t: matched expected %0d, got %0d", $time, want.hit, rsp_ch.matched);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_request > 0) begin
        stall_left = rsp_hold_request;
        rsp_hold_request = 0;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_INSERT;
    req_ch.address = '0;
    req_ch.prefix_length = '0;
    req_ch.port_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    kid_left[0] = '0;
    kid_right[0] = '0;
    node_mark[0] = 1'b0;
    node_port[0] = '0;
    free_node = 13'd1;
    default_port_q = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_directed_routes();
    test_random_traffic(500);
    test_backpressure();
    test_store_exhaustion();
    test_full_store_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_routes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_routes.size());
      fail_count++;
    end
    $display("covered %0d inserts (%0d refused on a full store, %0d nodes used)",
             n_inserts, n_full, free_node);
    $display("and %0d lookups (%0d matched) over %0d default port settings",
             n_lookups, n_hits, n_settings);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tlpm_pkg.sv
hw/rtl/tlpm_if.sv
hw/rtl/tlpm_node_store.sv
hw/rtl/trie_longest_prefix_match.sv
hw/rtl/tlpm_checker.sv
tb/sv/tb_top.sv
